/* design/lms_pkg.sv */
// Shared types and constants for the Laplacian mesh smoothing block.
// No dependencies; imported by every design file.
package lms_pkg;

	localparam int IDX_W     = 12;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = 19;
	localparam int CNT_OUT_W = 7;

	localparam int VTX_DEPTH_DEF      = 4096;
	localparam int MAX_NEIGHBOURS_DEF = 64;
	localparam int FRAC_BITS_DEF      = 16;

	localparam logic signed [DIFF_W-1:0] DIFFUSION_RESET = 19'sd32768;
	localparam logic [CNT_OUT_W-1:0]     CNT_OUT_MAX     = 7'd127;

	localparam logic OP_LOAD      = 1'b0;
	localparam logic OP_NEIGHBOUR = 1'b1;

	// one vertex position, [0] = x, [1] = y, [2] = z
	typedef logic [2:0][COORD_W-1:0] vec_t;

	typedef struct packed {
		logic                      op;
		logic [IDX_W-1:0]          vertex_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [IDX_W-1:0]          neighbour_index;
		logic                      neighbour_valid;
		logic                      last_of_vertex;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]          result_index;
		logic signed [COORD_W-1:0] new_x;
		logic signed [COORD_W-1:0] new_y;
		logic signed [COORD_W-1:0] new_z;
		logic [CNT_OUT_W-1:0]      neighbour_count;
		logic                      saturated;
	} result_t;

endpackage

/* design/lms_divider.sv */
// Bit-serial restoring divider: signed sum by unsigned nonzero count,
// quotient truncated toward zero. Depends on lms_pkg.
module lms_divider import lms_pkg::*; #(
	parameter int SUM_W = 38,
	parameter int CNT_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]          divisor,
	output logic                      done,
	output logic signed [COORD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [SUM_W-1:0]  quo_q;
	logic              neg_q;
	logic [CNT_W:0]    trial;
	logic              fits;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  quo_signed;

	assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : CNT_W'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	// average of 32-bit values always fits back in 32 bits
	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed'(quo_signed[COORD_W-1:0]);
	assign done       = done_q;

endmodule

/* design/lms_mac.sv */
// Shared multiplier with accumulator: a*b + c*d, round half up at FRAC_BITS,
// clamp to 32 bits. Depends on lms_pkg.
module lms_mac import lms_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int COEF_W    = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COEF_W-1:0]  coef_a,
	input  logic signed [COORD_W-1:0] val_a,
	input  logic signed [COEF_W-1:0]  coef_b,
	input  logic signed [COORD_W-1:0] val_b,
	output logic                      done,
	output logic signed [COORD_W-1:0] value,
	output logic                      clamped
);

	localparam int PROD_W = COEF_W + COORD_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int Q_W    = ACC_W - FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [Q_W-1:0]   QMAX = Q_W'(32'sh7FFFFFFF);
	localparam logic signed [Q_W-1:0]   QMIN = Q_W'(32'sh80000000);

	logic                       busy_q;
	logic [1:0]                 phase_q;
	logic                       done_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [COORD_W-1:0]  value_q;
	logic                       clamped_q;
	logic signed [COEF_W-1:0]   mul_c;
	logic signed [COORD_W-1:0]  mul_v;
	logic signed [PROD_W-1:0]   mul_out;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [Q_W-1:0]      q;

	// one multiplier: first operand pair on start, second in the cycle after
	assign mul_c   = busy_q ? coef_b : coef_a;
	assign mul_v   = busy_q ? val_b : val_a;
	assign mul_out = mul_c * mul_v;

	assign rnd = acc_q + HALF;
	assign q   = Q_W'(rnd >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd1;
			end else if (busy_q) begin
				phase_q <= phase_q + 1'b1;
				if (phase_q == 2'd3) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start || (busy_q && phase_q == 2'd1))
			prod_s1 <= mul_out;
		if (busy_q && phase_q == 2'd1)
			acc_q <= ACC_W'(prod_s1);
		if (busy_q && phase_q == 2'd2)
			acc_q <= acc_q + ACC_W'(prod_s1);
		if (busy_q && phase_q == 2'd3) begin
			if (q > QMAX) begin
				value_q   <= 32'sh7FFFFFFF;
				clamped_q <= 1'b1;
			end else if (q < QMIN) begin
				value_q   <= 32'sh80000000;
				clamped_q <= 1'b1;
			end else begin
				value_q   <= COORD_W'(q);
				clamped_q <= 1'b0;
			end
		end
	end

	assign done    = done_q;
	assign value   = value_q;
	assign clamped = clamped_q;

endmodule

/* design/laplacian_mesh_smoothing.sv */
// Laplacian mesh smoothing, one pass: vertex store, neighbor accumulation
// and blend sequencer. Depends on lms_pkg, lms_divider, lms_mac.
//
//  channel  | handshake                  | payload          | direction
//  ---------+----------------------------+------------------+----------
//  item     | item_valid / item_stall    | item_t           | in
//  result   | result_valid / result_stall| result_t         | out
//  cfg      | cfg_valid / cfg_ready      | cfg_data (19 b)  | in
//
// A load beat is written straight into the vertex store; a neighbor beat
// that does not close its run takes one vertex-memory read, then the
// accumulate. A closing beat then reads the target's old position and runs
// the bit-serial divider (SUM_W = 32 + clog2(MAX_NEIGHBOURS) bits) and the
// blend once per axis; with no counted corner it skips both. Either is held
// while an earlier result still sits stalled in the output register.
// Reset clears the sequencer, accumulators and diffusion (to 0.5 at Q.16);
// the vertex store is not cleared. item_stall is high while a beat works;
// a finished result waits in the output register while new beats enter.
module laplacian_mesh_smoothing import lms_pkg::*; #(
	parameter int VTX_DEPTH      = VTX_DEPTH_DEF,
	parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  item_t                    item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output result_t                  result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic signed [DIFF_W-1:0] cfg_data
);

	localparam int AW     = $clog2(VTX_DEPTH);
	localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
	localparam int SUM_W  = COORD_W + $clog2(MAX_NEIGHBOURS);
	// coefficient width holds both r and 1 - r
	localparam int COEF_W = ((FRAC_BITS + 2 > DIFF_W) ? FRAC_BITS + 2 : DIFF_W) + 1;
	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << FRAC_BITS);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_NBR   = 8'b0000_0010,
		S_OLD   = 8'b0000_0100,
		S_DIVGO = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_MACGO = 8'b0010_0000,
		S_MAC   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(VTX_DEPTH);
	endfunction

	state_t                    state_q;
	logic signed [DIFF_W-1:0]  diffusion_q;
	logic [IDX_W-1:0]          tgt_q;
	logic                      tgt_ok_q;
	logic                      use_q;
	logic                      last_q;
	logic signed [SUM_W-1:0]   sum_q [3];
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic [1:0]                coord_q;
	logic signed [COORD_W-1:0] avg_q;
	vec_t                      old_q;
	vec_t                      res_q;
	logic                      sat_q;
	logic                      result_valid_q;
	result_t                   result_q;

	vec_t                      vstore_q [VTX_DEPTH];
	vec_t                      rd_q;
	logic [AW-1:0]             rd_addr;
	logic                      rd_en;
	logic                      wr_en;
	vec_t                      wr_vec;
	logic                      accept;

	logic                      div_start;
	logic                      div_done;
	logic signed [COORD_W-1:0] div_quo;
	logic                      mac_start;
	logic                      mac_done;
	logic signed [COORD_W-1:0] mac_value;
	logic                      mac_clamped;
	logic [CNT_OUT_W-1:0]      count_out;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;

	// vertex store: one write port for loads, one registered read port
	assign wr_en     = accept && (item.op == OP_LOAD) && idx_ok(item.vertex_index);
	assign wr_vec[0] = item.coord_x;
	assign wr_vec[1] = item.coord_y;
	assign wr_vec[2] = item.coord_z;
	// idle: neighbor corner of the incoming beat; then the target's old position
	assign rd_addr   = (state_q == S_IDLE) ? AW'(item.neighbour_index) : AW'(tgt_q);
	assign rd_en     = (state_q == S_IDLE) || (state_q == S_NBR);

	always_ff @(posedge clk) begin
		if (wr_en)
			vstore_q[AW'(item.vertex_index)] <= wr_vec;
		if (rd_en)
			rd_q <= vstore_q[rd_addr];
	end

	assign div_start = (state_q == S_DIVGO);
	assign mac_start = (state_q == S_MACGO);

	lms_divider #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[coord_q]),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// blend: r*avg + (1 - r)*old
	lms_mac #(
		.FRAC_BITS (FRAC_BITS),
		.COEF_W    (COEF_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.coef_a  (COEF_W'(diffusion_q)),
		.val_a   (avg_q),
		.coef_b  (COEF_ONE - COEF_W'(diffusion_q)),
		.val_b   (signed'(old_q[coord_q])),
		.done    (mac_done),
		.value   (mac_value),
		.clamped (mac_clamped)
	);

	assign count_out = (32'(count_q) > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX : CNT_OUT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			diffusion_q    <= DIFFUSION_RESET;
			sum_q[0]       <= '0;
			sum_q[1]       <= '0;
			sum_q[2]       <= '0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			coord_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				diffusion_q <= cfg_data;
			// output register: load from S_OUT, empty when the beat leaves
			if (state_q == S_OUT && (!result_valid_q || !result_stall))
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && item.op == OP_NEIGHBOUR)
						state_q <= S_NBR;
				end
				S_NBR: begin
					// self corners, empty entries and out-of-table corners add nothing
					if (use_q) begin
						if (32'(count_q) >= 32'(MAX_NEIGHBOURS)) begin
							ovf_q <= 1'b1;
						end else begin
							sum_q[0] <= sum_q[0] + SUM_W'(signed'(rd_q[0]));
							sum_q[1] <= sum_q[1] + SUM_W'(signed'(rd_q[1]));
							sum_q[2] <= sum_q[2] + SUM_W'(signed'(rd_q[2]));
							count_q  <= count_q + 1'b1;
						end
					end
					state_q <= last_q ? S_OLD : S_IDLE;
				end
				S_OLD: begin
					coord_q <= '0;
					state_q <= (count_q == '0) ? S_OUT : S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_MACGO;
				end
				S_MACGO: begin
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (mac_done) begin
						if (coord_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							coord_q <= coord_q + 1'b1;
							state_q <= S_DIVGO;
						end
					end
				end
				S_OUT: begin
					// wait for the output register to free up
					if (!result_valid_q || !result_stall) begin
						sum_q[0]       <= '0;
						sum_q[1]       <= '0;
						sum_q[2]       <= '0;
						count_q        <= '0;
						ovf_q          <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (accept && item.op == OP_NEIGHBOUR) begin
			tgt_q    <= item.vertex_index;
			tgt_ok_q <= idx_ok(item.vertex_index);
			use_q    <= item.neighbour_valid
				&& (item.neighbour_index != item.vertex_index)
				&& idx_ok(item.neighbour_index);
			last_q   <= item.last_of_vertex;
		end
		if (state_q == S_OLD) begin
			// target outside the table reads as the origin
			old_q <= tgt_ok_q ? rd_q : '0;
			res_q <= tgt_ok_q ? rd_q : '0;
			sat_q <= ovf_q;
		end
		if (state_q == S_DIV && div_done)
			avg_q <= div_quo;
		if (state_q == S_MAC && mac_done) begin
			res_q[coord_q] <= mac_value;
			sat_q          <= sat_q | mac_clamped;
		end
		if (state_q == S_OUT && (!result_valid_q || !result_stall)) begin
			result_q.result_index    <= tgt_q;
			result_q.new_x           <= signed'(res_q[0]);
			result_q.new_y           <= signed'(res_q[1]);
			result_q.new_z           <= signed'(res_q[2]);
			result_q.neighbour_count <= count_out;
			result_q.saturated       <= sat_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* design/lms_checker.sv */
// Port-level checks for laplacian_mesh_smoothing, bound to the top level.
// Depends on lms_pkg.
module lms_checker import lms_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("stalled result payload changed");

	a_nbr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == OP_NEIGHBOUR |=> item_stall)
		else $error("neighbour beat did not occupy the block");

	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared while the block was idle");

	a_zero_count_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.neighbour_count == '0 |-> !result.saturated)
		else $error("unchanged vertex flagged as saturated");

endmodule

bind laplacian_mesh_smoothing lms_checker u_lms_checker (.*);

/* verif/tb_laplacian_mesh_smoothing.sv */
// Testbench for laplacian_mesh_smoothing: directed table, then random load/neighbor passes
// under several diffusion settings, checked against an in-bench predictor or typed rows.
// Depends on lms_pkg and the laplacian_mesh_smoothing RTL only.
`timescale 1ns / 1ps

module tb_laplacian_mesh_smoothing;
	import lms_pkg::*;

	localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] POS_MIN = 32'sh8000_0000;

	localparam logic signed [DIFF_W-1:0] R_MINUS_TWO = -19'sd131072;
	localparam logic signed [DIFF_W-1:0] R_TWO       = 19'sd131072;
	localparam logic signed [DIFF_W-1:0] R_ZERO      = 19'sd0;
	localparam logic signed [DIFF_W-1:0] R_ONE       = 19'sd65536;
	localparam logic signed [DIFF_W-1:0] R_TINY_NEG  = -19'sd1;

	// a closing beat runs the serial divider once per axis
	localparam int SUM_W        = COORD_W + $clog2(MAX_NEIGHBOURS_DEF);
	localparam int DRAIN_CYCLES = 3 * SUM_W + 40;
	localparam int IDLE_LIMIT   = 4000;
	localparam int NUM_PHASES   = 7;
	localparam int PHASE_ITEMS  = 40;

	// one line of the directed table: either a diffusion write or an input beat,
	// optionally with a hand-written expected result
	typedef struct packed {
		logic                     is_cfg;
		logic signed [DIFF_W-1:0] cfg_val;
		item_t                    beat;
		logic                     typed;
		result_t                  want;
	} row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     item_valid;
	logic                     item_stall;
	item_t                    item;
	logic                     result_valid;
	logic                     result_stall;
	result_t                  result;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic signed [DIFF_W-1:0] cfg_data;

	laplacian_mesh_smoothing i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: its own copy of the vertex table, accumulators
	// and the diffusion amount.
	// ---------------------------------------------------------------
	vec_t                mesh_pos [VTX_DEPTH_DEF];
	bit                  pos_known [VTX_DEPTH_DEF];
	logic [IDX_W-1:0]    known_idx [$];
	longint              acc_sum [3];
	int unsigned         corners;
	bit                  corner_spill;
	longint              diff_r;

	result_t             smoothed_q [$];
	result_t             want_res;

	int                  errors;
	int                  items_sent;
	int                  results_checked;
	int                  sat_seen;
	int                  cfg_writes;
	int                  idle_cycles;
	int                  stall_run;
	int                  free_run;
	bit                  steady;

	row_t                directed_rows [$];

	// r*mean + (1-r)*prev, rounded half up, clamped to 32 bits
	function automatic logic signed [COORD_W-1:0] blend_axis(input longint total,
			input int unsigned n, input logic signed [COORD_W-1:0] prev, inout bit clamp);
		longint mean;
		longint mix;
		longint q;
		if (n == 0)
			return prev;
		mean = total / longint'(n);   // truncates toward zero
		mix  = diff_r * mean + ((longint'(1) <<< FRAC_BITS_DEF) - diff_r) * longint'(prev);
		q    = (mix + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
		if (q > longint'(POS_MAX)) begin
			clamp = 1'b1;
			return POS_MAX;
		end
		if (q < longint'(POS_MIN)) begin
			clamp = 1'b1;
			return POS_MIN;
		end
		return q[COORD_W-1:0];
	endfunction

	// Applies one accepted beat to the predictor; returns 1 with the
	// smoothed vertex when the beat closes a target's run.
	function automatic bit smooth_vertex(input item_t beat, output result_t res);
		vec_t prev;
		bit   clamp;
		res = '0;
		if (beat.op == OP_LOAD) begin
			if (!pos_known[beat.vertex_index]) begin
				pos_known[beat.vertex_index] = 1'b1;
				known_idx.push_back(beat.vertex_index);
			end
			mesh_pos[beat.vertex_index] = {beat.coord_z, beat.coord_y, beat.coord_x};
			return 1'b0;
		end
		// self corners and empty entries add nothing
		if (beat.neighbour_valid && beat.neighbour_index != beat.vertex_index) begin
			if (corners >= MAX_NEIGHBOURS_DEF)
				corner_spill = 1'b1;
			else begin
				for (int a = 0; a < 3; a++)
					acc_sum[a] += longint'(signed'(mesh_pos[beat.neighbour_index][a]));
				corners++;
			end
		end
		if (!beat.last_of_vertex)
			return 1'b0;
		prev  = mesh_pos[beat.vertex_index];
		clamp = corner_spill;
		res.result_index    = beat.vertex_index;
		res.new_x           = blend_axis(acc_sum[0], corners, signed'(prev[0]), clamp);
		res.new_y           = blend_axis(acc_sum[1], corners, signed'(prev[1]), clamp);
		res.new_z           = blend_axis(acc_sum[2], corners, signed'(prev[2]), clamp);
		res.neighbour_count = (corners > 127) ? CNT_OUT_MAX : CNT_OUT_W'(corners);
		res.saturated       = clamp;
		for (int a = 0; a < 3; a++)
			acc_sum[a] = 0;
		corners      = 0;
		corner_spill = 1'b0;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return POS_MAX;
			1:       return POS_MIN;
			2:       return '0;
			3, 4:    return $urandom_range(0, 2097151) - 1048576;   // within +-16.0
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] rand_index();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return IDX_W'($urandom_range(0, VTX_DEPTH_DEF - 1));
		endcase
	endfunction

	// only vertices already loaded are ever named, so no unwritten entry is read
	function automatic logic [IDX_W-1:0] pick_known();
		return known_idx[$urandom_range(0, known_idx.size() - 1)];
	endfunction

	function automatic item_t load_item(input logic [IDX_W-1:0] idx,
			input logic signed [COORD_W-1:0] x, y, z);
		item_t b;
		b                 = '0;
		b.op              = OP_LOAD;
		b.vertex_index    = idx;
		b.coord_x         = x;
		b.coord_y         = y;
		b.coord_z         = z;
		b.neighbour_index = IDX_W'($urandom);
		b.neighbour_valid = 1'($urandom);
		b.last_of_vertex  = 1'($urandom);
		return b;
	endfunction

	// coordinates of a neighbor beat are don't-care; fill them with noise
	function automatic item_t link_item(input logic [IDX_W-1:0] tgt, nb, input bit nv, last);
		item_t b;
		b                 = '0;
		b.op              = OP_NEIGHBOUR;
		b.vertex_index    = tgt;
		b.coord_x         = rand_coord();
		b.coord_y         = rand_coord();
		b.coord_z         = rand_coord();
		b.neighbour_index = nb;
		b.neighbour_valid = nv;
		b.last_of_vertex  = last;
		return b;
	endfunction

	function automatic result_t vertex_res(input logic [IDX_W-1:0] idx,
			input logic signed [COORD_W-1:0] x, y, z, input int cnt, input bit sat);
		result_t r;
		r.result_index    = idx;
		r.new_x           = x;
		r.new_y           = y;
		r.new_z           = z;
		r.neighbour_count = CNT_OUT_W'(cnt);
		r.saturated       = sat;
		return r;
	endfunction

	function automatic row_t plain_row(input item_t beat);
		row_t r;
		r      = '0;
		r.beat = beat;
		return r;
	endfunction

	function automatic row_t checked_row(input item_t beat, input result_t want);
		row_t r;
		r       = '0;
		r.beat  = beat;
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic row_t setting_row(input logic signed [DIFF_W-1:0] v);
		row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	// Presents one beat, waits for acceptance, predicts, then maybe idles.
	// With no gap valid stays high so the next call just swaps the payload.
	task automatic send_item(input item_t beat, input bit typed, input result_t typed_res);
		result_t res;
		int      gap;
		item_valid <= 1'b1;
		item       <= beat;
		do @(posedge clk); while (item_stall);
		items_sent++;
		if (smooth_vertex(beat, res))
			smoothed_q.push_back(typed ? typed_res : res);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every expected result, then give a non-closing
	// beat time to finish inside the block.
	task automatic settle();
		item_valid <= 1'b0;
		while (smoothed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_diffusion(input logic signed [DIFF_W-1:0] r);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		diff_r = r;
		cfg_writes++;
	endtask

	// ---------------------------------------------------------------
	// Result side: random stall, check each accepted beat in order.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (smoothed_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat for vertex %0d",
							result.result_index);
					errors++;
				end else begin
					want_res = smoothed_q.pop_front();
					results_checked++;
					if (result.saturated === 1'b1)
						sat_seen++;
					if (result.result_index !== want_res.result_index ||
							result.new_x !== want_res.new_x ||
							result.new_y !== want_res.new_y ||
							result.new_z !== want_res.new_z ||
							result.neighbour_count !== want_res.neighbour_count ||
							result.saturated !== want_res.saturated) begin
						if (errors < 10) begin
							$display("mismatch want: idx=%0d x=%0d y=%0d z=%0d n=%0d sat=%0b",
								want_res.result_index, want_res.new_x, want_res.new_y,
								want_res.new_z, want_res.neighbour_count,
								want_res.saturated);
							$display("          got: idx=%0d x=%0d y=%0d z=%0d n=%0d sat=%0b",
								result.result_index, result.new_x, result.new_y,
								result.new_z, result.neighbour_count, result.saturated);
						end
						errors++;
					end
				end
			end
			// alternate free stretches and stall stretches
			if (stall_run > 0) begin
				result_stall <= 1'b1;
				stall_run--;
			end else if (free_run > 0) begin
				result_stall <= 1'b0;
				free_run--;
			end else begin
				result_stall <= 1'b0;
				free_run  = $urandom_range(0, 12);
				stall_run = pick_gap();
			end
		end
	end

	// Watchdog: too long with no beat moving on any channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int                       n_loads;
		int                       budget;
		int                       len;
		int                       noise;
		logic [IDX_W-1:0]         tgt;
		logic [IDX_W-1:0]         nb;
		logic [IDX_W-1:0]         owner;
		logic signed [DIFF_W-1:0] r;
		bit                       long_run;

		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		errors       = 0;
		idle_cycles  = 0;
		stall_run    = 0;
		free_run     = 0;
		steady       = 1'b0;
		corners      = 0;
		corner_spill = 1'b0;
		diff_r       = DIFFUSION_RESET;
		for (int a = 0; a < 3; a++)
			acc_sum[a] = 0;

		// Directed part. Diffusion starts at its reset value, one half.
		// Extreme corners first: full-scale max, full-scale min.
		directed_rows.push_back(plain_row(load_item(12'd0, POS_MAX, POS_MAX, POS_MAX)));
		directed_rows.push_back(plain_row(load_item(12'd1, POS_MIN, POS_MIN, POS_MIN)));
		directed_rows.push_back(plain_row(load_item(12'd2, 32'sh0001_0000,
			-32'sh0001_0000, 32'sd0)));
		directed_rows.push_back(plain_row(load_item(12'd4095, 32'sh1234_5678,
			-32'sd5, 32'sd7)));
		// isolated target, and a run holding only its own corner: both keep the old spot
		directed_rows.push_back(checked_row(link_item(12'd2, 12'd4095, 1'b0, 1'b1),
			vertex_res(12'd2, 32'sh0001_0000, -32'sh0001_0000, 32'sd0, 0, 1'b0)));
		directed_rows.push_back(checked_row(link_item(12'd2, 12'd2, 1'b1, 1'b1),
			vertex_res(12'd2, 32'sh0001_0000, -32'sh0001_0000, 32'sd0, 0, 1'b0)));
		// halfway between max and min lands on zero
		directed_rows.push_back(checked_row(link_item(12'd0, 12'd1, 1'b1, 1'b1),
			vertex_res(12'd0, 32'sd0, 32'sd0, 32'sd0, 1, 1'b0)));
		// duplicate corner from a shared face, then a three-corner run
		directed_rows.push_back(plain_row(link_item(12'd1, 12'd0, 1'b1, 1'b0)));
		directed_rows.push_back(plain_row(link_item(12'd1, 12'd0, 1'b1, 1'b1)));
		directed_rows.push_back(plain_row(link_item(12'd4095, 12'd0, 1'b1, 1'b0)));
		directed_rows.push_back(plain_row(link_item(12'd4095, 12'd1, 1'b1, 1'b0)));
		directed_rows.push_back(plain_row(link_item(12'd4095, 12'd2, 1'b1, 1'b1)));
		// r = -2 and r = +2 push every axis past full scale
		directed_rows.push_back(setting_row(R_MINUS_TWO));
		directed_rows.push_back(checked_row(link_item(12'd0, 12'd1, 1'b1, 1'b1),
			vertex_res(12'd0, POS_MAX, POS_MAX, POS_MAX, 1, 1'b1)));
		directed_rows.push_back(checked_row(link_item(12'd1, 12'd0, 1'b1, 1'b1),
			vertex_res(12'd1, POS_MIN, POS_MIN, POS_MIN, 1, 1'b1)));
		directed_rows.push_back(setting_row(R_TWO));
		directed_rows.push_back(checked_row(link_item(12'd0, 12'd1, 1'b1, 1'b1),
			vertex_res(12'd0, POS_MIN, POS_MIN, POS_MIN, 1, 1'b1)));
		// r = 0 leaves the vertex where it was
		directed_rows.push_back(setting_row(R_ZERO));
		directed_rows.push_back(checked_row(link_item(12'd4095, 12'd0, 1'b1, 1'b1),
			vertex_res(12'd4095, 32'sh1234_5678, -32'sd5, 32'sd7, 1, 1'b0)));
		// r = 1: pure average; empty entry inside a run adds nothing
		directed_rows.push_back(setting_row(R_ONE));
		directed_rows.push_back(plain_row(link_item(12'd0, 12'd2, 1'b1, 1'b0)));
		directed_rows.push_back(plain_row(link_item(12'd0, 12'd4095, 1'b1, 1'b1)));
		directed_rows.push_back(plain_row(link_item(12'd2, 12'd0, 1'b0, 1'b0)));
		directed_rows.push_back(plain_row(link_item(12'd2, 12'd1, 1'b1, 1'b1)));
		directed_rows.push_back(setting_row(R_TINY_NEG));
		directed_rows.push_back(plain_row(link_item(12'd2, 12'd0, 1'b1, 1'b1)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_cfg)
				write_diffusion(directed_rows[k].cfg_val);
			else
				send_item(directed_rows[k].beat, directed_rows[k].typed,
					directed_rows[k].want);
		end

		// Random passes: each one sets r, loads a few vertices, then sends
		// well-formed neighbor runs with some noise mixed in.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       r = DIFFUSION_RESET;
				1:       r = R_MINUS_TWO;
				2:       r = R_TWO;
				3:       r = R_ZERO;
				4:       r = R_ONE;
				default: r = DIFF_W'($urandom_range(0, 262144) - 131072);
			endcase
			write_diffusion(r);
			steady = (ph % 3 == 2);   // no idling on either side this pass

			n_loads = (ph == 0) ? 24 : $urandom_range(4, 10);
			repeat (n_loads)
				send_item(load_item(rand_index(), rand_coord(), rand_coord(), rand_coord()),
					1'b0, '0);

			budget   = items_sent + PHASE_ITEMS;
			long_run = (ph == 1 || ph == 4);   // these passes open with a run longer than MAX_NEIGHBOURS_DEF
			while (items_sent < budget) begin
				tgt = pick_known();
				if (!long_run && $urandom_range(0, 99) < 10) begin
					send_item(link_item(tgt, pick_known(), 1'b0, 1'b1), 1'b0, '0);
					continue;
				end
				len      = long_run ? $urandom_range(MAX_NEIGHBOURS_DEF + 2,
					MAX_NEIGHBOURS_DEF + 8) : $urandom_range(1, 10);
				long_run = 1'b0;
				for (int j = 0; j < len; j++) begin
					noise = $urandom_range(0, 99);
					if (noise < 4 && j != len - 1) begin
						// reload mid-run; accumulators must be left alone
						send_item(load_item(rand_index(), rand_coord(), rand_coord(),
							rand_coord()), 1'b0, '0);
					end else begin
						nb    = (noise < 12) ? tgt : pick_known();
						owner = (noise >= 18 && noise < 22) ? pick_known() : tgt;
						send_item(link_item(owner, nb, !(noise >= 12 && noise < 18),
							j == len - 1), 1'b0, '0);
					end
				end
			end
		end
		steady = 1'b0;

		settle();
		$display("run covered %0d input beats, %0d results checked (%0d saturated), %0d r writes",
			items_sent, results_checked, sat_seen, cfg_writes);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
design/lms_pkg.sv
design/lms_divider.sv
design/lms_mac.sv
design/laplacian_mesh_smoothing.sv
design/lms_checker.sv
verif/tb_laplacian_mesh_smoothing.sv
